// ===== rtl/pco_tlv_stream_decoder_unit_assert.svh =====
// Assertion macros shared by the decoder RTL. The enclosing module must
// provide clk_i and rst_ni. Arguments must not contain top-level commas.
`ifndef PCO_TLV_STREAM_DECODER_UNIT_ASSERT_SVH
`define PCO_TLV_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every clock edge outside reset.
`define PCOTLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition holds in the cycle after another one.
`define PCOTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCOTLV_ASSERT(lbl, prop, msg)
`define PCOTLV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/pcotlv_pkg.sv =====
package pcotlv_pkg;

  localparam int unsigned CountW = 6;
  localparam int unsigned IndexW = 5;

  // Header octet layout: extension bit, spare bits and protocol field.
  localparam int unsigned  ExtBit    = 7;
  localparam logic [7:0]   SpareMask = 8'h78;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_IDHI    = 3'd1,
    PH_IDLO    = 3'd2,
    PH_LEN     = 3'd3,
    PH_CONTENT = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_ID_HIGH = 3'd1,
    ROLE_ID_LOW  = 3'd2,
    ROLE_LENGTH  = 3'd3,
    ROLE_CONTENT = 3'd4,
    ROLE_IGNORED = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXT_CLEAR = 3'd1,
    ST_SPARE_SET = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_TRAILING  = 3'd5
  } status_e;

  // One decoded result, as produced by the parser for one octet.
  typedef struct packed {
    role_e               byte_role;
    logic [2:0]          config_protocol;
    logic [IndexW-1:0]   container_index;
    logic [15:0]         container_id;
    logic [7:0]          container_length;
    logic [7:0]          content_offset;
    logic                container_done;
    logic [CountW-1:0]   container_count;
    logic                message_done;
    status_e             status;
  } result_t;

endpackage

// ===== rtl/pcotlv_if.sv =====
// Request channel carrying raw octets into the decoder.
interface pcotlv_in_if
  import pcotlv_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

// Request channel carrying one decoded result per octet.
interface pcotlv_out_if
  import pcotlv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        byte_role;
  logic [2:0]        config_protocol;
  logic [IndexW-1:0] container_index;
  logic [15:0]       container_id;
  logic [7:0]        container_length;
  logic [7:0]        content_offset;
  logic              container_done;
  logic [CountW-1:0] container_count;
  logic              message_done;
  logic [2:0]        status;

  modport source (
    output valid, byte_role, config_protocol, container_index, container_id,
           container_length, content_offset, container_done, container_count,
           message_done, status,
    input  ready
  );
  modport sink (
    input  valid, byte_role, config_protocol, container_index, container_id,
           container_length, content_offset, container_done, container_count,
           message_done, status,
    output ready
  );
endinterface

// ===== rtl/pcotlv_parser.sv =====
`include "pco_tlv_stream_decoder_unit_assert.svh"

// Parse state and the per-octet decode. The result is combinational from
// the current state and the octet; the state advances on accept_i.
module pcotlv_parser
  import pcotlv_pkg::*;
#(
  parameter int unsigned MAX_CONTAINERS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output result_t    result_o
);

  phase_e            phase_q, phase_d;
  logic [2:0]        protocol_q, protocol_d;
  logic [15:0]       id_q, id_d;
  logic [7:0]        length_q, length_d;
  logic [7:0]        offset_q, offset_d;
  logic [CountW-1:0] count_q, count_d;
  status_e           error_q, error_d;

  status_e           err;
  logic              content_end;

  assign content_end = ({1'b0, offset_q} + 9'd1) >= {1'b0, length_q};

  always_comb begin
    phase_d    = phase_q;
    protocol_d = protocol_q;
    id_d       = id_q;
    length_d   = length_q;
    offset_d   = offset_q;
    count_d    = count_q;
    error_d    = error_q;
    err        = ST_OK;

    result_o                  = '0;
    result_o.byte_role        = ROLE_IGNORED;
    result_o.status           = ST_OK;
    result_o.container_index  = count_q[IndexW-1:0];
    result_o.message_done     = last_i;

    unique case (phase_q)
      PH_HEADER: begin
        result_o.byte_role = ROLE_HEADER;
        if (!data_byte_i[ExtBit]) begin
          err = ST_EXT_CLEAR;
        end else if ((data_byte_i & SpareMask) != 8'h00) begin
          err = ST_SPARE_SET;
        end
        if (err != ST_OK) begin
          protocol_d = 3'd0;
        end else begin
          protocol_d = data_byte_i[2:0];
          phase_d    = PH_IDHI;
        end
      end
      PH_IDHI: begin
        result_o.byte_role = ROLE_ID_HIGH;
        id_d    = {data_byte_i, 8'h00};
        phase_d = PH_IDLO;
        if (last_i) begin
          result_o.status = ST_TRAILING;
        end
      end
      PH_IDLO: begin
        result_o.byte_role    = ROLE_ID_LOW;
        id_d                  = id_q | {8'h00, data_byte_i};
        result_o.container_id = id_d;
        phase_d               = PH_LEN;
        if (last_i) begin
          result_o.status = ST_TRAILING;
        end
      end
      PH_LEN: begin
        result_o.byte_role        = ROLE_LENGTH;
        result_o.container_id     = id_q;
        result_o.container_length = data_byte_i;
        length_d                  = data_byte_i;
        if (count_q >= CountW'(MAX_CONTAINERS)) begin
          err = ST_TOO_MANY;
        end else if (data_byte_i == 8'h00) begin
          result_o.container_done = 1'b1;
          count_d = count_q + CountW'(1);
          phase_d = PH_IDHI;
        end else begin
          offset_d = 8'h00;
          phase_d  = PH_CONTENT;
          if (last_i) begin
            result_o.status = ST_TRUNCATED;
          end
        end
      end
      PH_CONTENT: begin
        result_o.byte_role        = ROLE_CONTENT;
        result_o.container_id     = id_q;
        result_o.container_length = length_q;
        result_o.content_offset   = offset_q;
        if (content_end) begin
          result_o.container_done = 1'b1;
          count_d = count_q + CountW'(1);
          phase_d = PH_IDHI;
        end else begin
          offset_d = offset_q + 8'd1;
          if (last_i) begin
            result_o.status = ST_TRUNCATED;
          end
        end
      end
      default: begin
        result_o.byte_role = ROLE_IGNORED;
        result_o.status    = error_q;
      end
    endcase

    // A detected error freezes the message until its last octet.
    if (err != ST_OK) begin
      error_d         = err;
      result_o.status = err;
      phase_d         = PH_IGNORE;
    end

    result_o.config_protocol = protocol_d;
    result_o.container_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      protocol_q <= '0;
      id_q       <= '0;
      length_q   <= '0;
      offset_q   <= '0;
      count_q    <= '0;
      error_q    <= ST_OK;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q    <= PH_HEADER;
        protocol_q <= '0;
        id_q       <= '0;
        length_q   <= '0;
        offset_q   <= '0;
        count_q    <= '0;
        error_q    <= ST_OK;
      end else begin
        phase_q    <= phase_d;
        protocol_q <= protocol_d;
        id_q       <= id_d;
        length_q   <= length_d;
        offset_q   <= offset_d;
        count_q    <= count_d;
        error_q    <= error_d;
      end
    end
  end

  `PCOTLV_ASSERT(a_count_bound, count_q <= CountW'(MAX_CONTAINERS), "container count above limit")
  `PCOTLV_ASSERT(a_offset_in_len, (phase_q == PH_CONTENT) |-> (offset_q < length_q), "offset past length")
  `PCOTLV_ASSERT(a_error_ignore, (phase_q == PH_IGNORE) == (error_q != ST_OK), "error and ignore disagree")

endmodule

// ===== rtl/pco_tlv_stream_decoder_unit.sv =====
// Protocol configuration options decoder. Octets of one options element
// enter on in_i, the final octet flagged by last; each accepted octet
// produces exactly one result on out_o in the following cycle, describing its role
// (header, id high, id low, length, content, or ignored after an error) and
// the container it belongs to. While out_o is ready, the block sustains
// one octet per clock cycle: the only loop is the parse state in the
// parser, which updates on each accepted octet, and a single output
// register holds the result while the sink stalls. Parse state returns
// to reset after every last octet, so elements are independent.
`include "pco_tlv_stream_decoder_unit_assert.svh"

module pco_tlv_stream_decoder_unit
  import pcotlv_pkg::*;
#(
  // Containers allowed per element before the length octet is rejected.
  parameter int unsigned MAX_CONTAINERS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcotlv_in_if.sink     in_i,
  pcotlv_out_if.source  out_o
);

  logic    accept;
  result_t result;
  result_t out_q;
  logic    out_valid_q;

  // A new request is taken whenever the output register is empty or is
  // being drained in this same cycle, so the stream flows without bubbles.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  pcotlv_parser #(
    .MAX_CONTAINERS (MAX_CONTAINERS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last),
    .result_o    (result)
  );

  // The valid flag is control state and is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.byte_role        = out_q.byte_role;
  assign out_o.config_protocol  = out_q.config_protocol;
  assign out_o.container_index  = out_q.container_index;
  assign out_o.container_id     = out_q.container_id;
  assign out_o.container_length = out_q.container_length;
  assign out_o.content_offset   = out_q.content_offset;
  assign out_o.container_done   = out_q.container_done;
  assign out_o.container_count  = out_q.container_count;
  assign out_o.message_done     = out_q.message_done;
  assign out_o.status           = out_q.status;

  // Every accepted octet must show up as a pending result next cycle.
  `PCOTLV_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_q, "accepted octet produced no result")

endmodule
